@@ src/tbdlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbdlc_pkg
// Shared types and constants for the two-button debounced level control.
// ----------------------------------------------------------------------------
package tbdlc_pkg;

  localparam int LEVEL_BITS  = 16;
  localparam int SUM_W       = ((LEVEL_BITS > 16) ? LEVEL_BITS : 16) + 1;
  localparam int HOLD_W      = 9;
  localparam int DIV_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LEVEL_BITS-1:0] BRIGHT_RESET = LEVEL_BITS'(100);
  localparam logic [DIV_W-1:0]      DIV_RESET    = DIV_W'(8);
  localparam logic [DIV_W-1:0]      DIV_LIMIT    = DIV_W'(31);
  localparam logic [SUM_W-1:0]      LEVEL_LIMIT  =
    SUM_W'((64'd1 << LEVEL_BITS) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS = 3'd0,
    REG_LEVEL_STEP     = 3'd1,
    REG_LEVEL_MAX      = 3'd2,
    REG_DIVISOR_STEP   = 3'd3,
    REG_DIVISOR_MAX    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [11:0] level_step;
    logic [15:0] level_max;
    logic [3:0]  divisor_step;
    logic [4:0]  divisor_max;
  } cfg_t;

  typedef struct packed {
    logic raise;
    logic lower;
  } action_t;

endpackage
`default_nettype wire

@@ src/tbdlc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbdlc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tbdlc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [tbdlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tbdlc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tbdlc_pkg::cfg_t                         cfg
);
  import tbdlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= 8'd50;
      cfg.level_step     <= 12'd100;
      cfg.level_max      <= 16'd2000;
      cfg.divisor_step   <= 4'd2;
      cfg.divisor_max    <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data[7:0];
        REG_LEVEL_STEP:     cfg.level_step     <= cfg_data[11:0];
        REG_LEVEL_MAX:      cfg.level_max      <= cfg_data[15:0];
        REG_DIVISOR_STEP:   cfg.divisor_step   <= cfg_data[3:0];
        REG_DIVISOR_MAX:    cfg.divisor_max    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/tbdlc_press_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbdlc_press_fsm
// Debounce and release state machine; flags one action tick per debounced press.
// ----------------------------------------------------------------------------
module tbdlc_press_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        a_level,
  input  wire logic        b_level,
  input  wire logic [7:0]  debounce_ticks,
  output tbdlc_pkg::action_t action
);
  import tbdlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DEB_A = 3'd1,
    ST_REL_A = 3'd2,
    ST_DEB_B = 3'd3,
    ST_REL_B = 3'd4,
    ST_ACT_A = 3'd5,
    ST_ACT_B = 3'd6
  } state_t;

  state_t            state;
  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_inc;
  logic              a_pressed;
  logic              b_pressed;
  logic              held;

  assign a_pressed = ~a_level;
  assign b_pressed = ~b_level;
  assign held      = (state == ST_DEB_A) ? a_pressed : b_pressed;
  assign hold_inc  = hold_count + HOLD_W'(1);

  assign action.raise = (state == ST_ACT_A);
  assign action.lower = (state == ST_ACT_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_count <= '0;
    end else if (step) begin
      unique case (state)
        ST_IDLE: begin
          hold_count <= '0;
          if (b_pressed) begin
            state <= ST_DEB_B;
          end else if (a_pressed) begin
            state <= ST_DEB_A;
          end
        end
        ST_DEB_A, ST_DEB_B: begin
          if (held) begin
            if (hold_inc > HOLD_W'(debounce_ticks)) begin
              hold_count <= '0;
              state      <= (state == ST_DEB_A) ? ST_REL_A : ST_REL_B;
            end else begin
              hold_count <= hold_inc;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_REL_A: if (!a_pressed) state <= ST_ACT_A;
        ST_REL_B: if (!b_pressed) state <= ST_ACT_B;
        ST_ACT_A: state <= ST_IDLE;
        ST_ACT_B: state <= ST_IDLE;
        default: begin
          state      <= ST_IDLE;
          hold_count <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/tbdlc_level_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbdlc_level_unit
// LED level and buzzer divisor registers with saturating step updates.
// ----------------------------------------------------------------------------
module tbdlc_level_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire tbdlc_pkg::action_t            action,
  input  wire tbdlc_pkg::cfg_t               cfg,
  output logic [15:0]                        lamp_level_next,
  output logic [tbdlc_pkg::DIV_W-1:0]        divisor_next
);
  import tbdlc_pkg::*;

  logic [LEVEL_BITS-1:0] brightness;
  logic [LEVEL_BITS-1:0] brightness_next;
  logic [DIV_W-1:0]      duty_divisor;
  logic [SUM_W-1:0]      bright_ext;
  logic [SUM_W-1:0]      step_ext;
  logic [SUM_W-1:0]      bright_sum;
  logic [SUM_W-1:0]      next_ext;
  logic [DIV_W:0]        div_sum;

  assign bright_ext = SUM_W'(brightness);
  assign step_ext   = SUM_W'(cfg.level_step);
  assign bright_sum = bright_ext + step_ext;
  assign div_sum    = (DIV_W+1)'(duty_divisor) + (DIV_W+1)'(cfg.divisor_step);

  always_comb begin
    brightness_next = brightness;
    divisor_next    = duty_divisor;
    if (action.raise) begin
      if (bright_ext < SUM_W'(cfg.level_max)) begin
        brightness_next = (bright_sum > LEVEL_LIMIT) ?
                          LEVEL_BITS'(LEVEL_LIMIT) : LEVEL_BITS'(bright_sum);
      end
      if (duty_divisor < cfg.divisor_max) begin
        divisor_next = (div_sum > (DIV_W+1)'(DIV_LIMIT)) ? DIV_LIMIT
                                                         : div_sum[DIV_W-1:0];
      end
    end else if (action.lower) begin
      if (bright_ext > step_ext) begin
        brightness_next = LEVEL_BITS'(bright_ext - step_ext);
      end
      if (duty_divisor > DIV_W'(cfg.divisor_step)) begin
        divisor_next = duty_divisor - DIV_W'(cfg.divisor_step);
      end
    end
  end

  assign next_ext        = SUM_W'(brightness_next);
  assign lamp_level_next = next_ext[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= BRIGHT_RESET;
      duty_divisor <= DIV_RESET;
    end else if (step) begin
      brightness   <= brightness_next;
      duty_divisor <= divisor_next;
    end
  end

endmodule
`default_nettype wire

@@ src/two_button_debounced_level_control.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_button_debounced_level_control
// Debounced two-button control of an LED level and a buzzer divisor.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid/in_ready     button_a_level, button_b_level
//   out      source     out_valid/out_ready   lamp_level, buzzer_divisor,
//                                             raise_done, lower_done
//   cfg      sink       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; each input
// passes the input register, then the result register.
// Reset is synchronous; it restores register defaults and the press state.
// A stalled result holds in the result register while the input register
// keeps one more transaction; cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_button_debounced_level_control (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               button_a_level,
  input  wire logic                               button_b_level,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [15:0]                             lamp_level,
  output logic [tbdlc_pkg::DIV_W-1:0]             buzzer_divisor,
  output logic                                    raise_done,
  output logic                                    lower_done,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tbdlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tbdlc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tbdlc_pkg::*;

  cfg_t             cfg;
  action_t          action;
  logic             stage_valid;
  logic             stage_a;
  logic             stage_b;
  logic             advance;
  logic [15:0]      lamp_level_next;
  logic [DIV_W-1:0] divisor_next;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  tbdlc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbdlc_press_fsm u_press_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .a_level        (stage_a),
    .b_level        (stage_b),
    .debounce_ticks (cfg.debounce_ticks),
    .action         (action)
  );

  tbdlc_level_unit u_level_unit (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .action          (action),
    .cfg             (cfg),
    .lamp_level_next (lamp_level_next),
    .divisor_next    (divisor_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_a <= button_a_level;
      stage_b <= button_b_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_level     <= lamp_level_next;
      buzzer_divisor <= divisor_next;
      raise_done     <= action.raise;
      lower_done     <= action.lower;
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-button debounced level control. Button
// ticks go in over a valid/ready channel and a scoreboard class predicts the
// LED level, buzzer divisor and action flags of every tick. Each returned
// transaction is compared field by field with the oldest prediction. The
// register settings change between phases while the block is drained, and
// both channels stall at random outside phase 0, with one long output hold-off per phase.
// ----------------------------------------------------------------------------
module testbench;
  import tbdlc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned IDLE_PERCENT = 36;
  localparam int unsigned HOLDOFF_LEN  = 60;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned REG_COUNT    = 5;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;

  typedef enum logic [2:0] {
    PS_IDLE  = 3'd0,
    PS_DEB_A = 3'd1,
    PS_REL_A = 3'd2,
    PS_DEB_B = 3'd3,
    PS_REL_B = 3'd4,
    PS_ACT_A = 3'd5,
    PS_ACT_B = 3'd6
  } press_state_t;

  typedef struct packed {
    logic [15:0]      led;
    logic [DIV_W-1:0] divisor;
    logic             raise;
    logic             lower;
  } level_result_t;

  class level_scoreboard;
    cfg_t                  regs;
    press_state_t          press;
    logic [HOLD_W-1:0]     hold;
    logic [LEVEL_BITS-1:0] brightness;
    logic [DIV_W-1:0]      divisor;
    level_result_t         expected_levels[$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           raises;
    int unsigned           lowers;

    function new();
      regs.debounce_ticks = 8'd50;
      regs.level_step     = 12'd100;
      regs.level_max      = 16'd2000;
      regs.divisor_step   = 4'd2;
      regs.divisor_max    = 5'd16;
      press      = PS_IDLE;
      hold       = '0;
      brightness = BRIGHT_RESET;
      divisor    = DIV_RESET;
      mismatches = 0;
      checked    = 0;
      raises     = 0;
      lowers     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_DEBOUNCE_TICKS: regs.debounce_ticks = data[7:0];
        REG_LEVEL_STEP:     regs.level_step     = data[11:0];
        REG_LEVEL_MAX:      regs.level_max      = data[15:0];
        REG_DIVISOR_STEP:   regs.divisor_step   = data[3:0];
        REG_DIVISOR_MAX:    regs.divisor_max    = data[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    function void note_buttons(logic a_level, logic b_level);
      logic             a_down;
      logic             b_down;
      logic             held;
      logic [SUM_W-1:0] sum;
      logic [DIV_W:0]   dsum;
      level_result_t    outcome;
      a_down = !a_level;
      b_down = !b_level;
      outcome.raise = 1'b0;
      outcome.lower = 1'b0;
      case (press)
        PS_IDLE: begin
          if (a_down) press = PS_DEB_A;
          if (b_down) press = PS_DEB_B;
          hold = '0;
        end
        PS_DEB_A, PS_DEB_B: begin
          held = (press == PS_DEB_A) ? a_down : b_down;
          if (held) begin
            hold = hold + 1'b1;
            if (hold > {1'b0, regs.debounce_ticks}) begin
              hold  = '0;
              press = (press == PS_DEB_A) ? PS_REL_A : PS_REL_B;
            end
          end else begin
            press = PS_IDLE;
          end
        end
        PS_REL_A: if (!a_down) press = PS_ACT_A;
        PS_REL_B: if (!b_down) press = PS_ACT_B;
        PS_ACT_A: begin
          press = PS_IDLE;
          if (brightness < regs.level_max) begin
            sum = SUM_W'(brightness) + SUM_W'(regs.level_step);
            brightness = (sum > LEVEL_LIMIT) ? LEVEL_LIMIT[LEVEL_BITS-1:0]
                                             : sum[LEVEL_BITS-1:0];
          end
          if (divisor < regs.divisor_max) begin
            dsum = {1'b0, divisor} + (DIV_W+1)'(regs.divisor_step);
            divisor = (dsum > {1'b0, DIV_LIMIT}) ? DIV_LIMIT : dsum[DIV_W-1:0];
          end
          outcome.raise = 1'b1;
        end
        PS_ACT_B: begin
          press = PS_IDLE;
          if (brightness > regs.level_step)
            brightness = brightness - LEVEL_BITS'(regs.level_step);
          if (divisor > regs.divisor_step) divisor = divisor - DIV_W'(regs.divisor_step);
          outcome.lower = 1'b1;
        end
        default: begin
          press = PS_IDLE;
          hold  = '0;
        end
      endcase
      outcome.led     = 16'(brightness);
      outcome.divisor = divisor;
      expected_levels.push_back(outcome);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_levels(level_result_t seen);
      level_result_t want;
      if (expected_levels.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (want.raise) raises++;
      if (want.lower) lowers++;
      if (seen.led !== want.led)
        report_mismatch($sformatf("lamp_level %0d, want %0d", seen.led, want.led));
      if (seen.divisor !== want.divisor)
        report_mismatch($sformatf("buzzer_divisor %0d, want %0d", seen.divisor, want.divisor));
      if (seen.raise !== want.raise)
        report_mismatch($sformatf("raise_done %0b, want %0b", seen.raise, want.raise));
      if (seen.lower !== want.lower)
        report_mismatch($sformatf("lower_done %0b, want %0b", seen.lower, want.lower));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic button_a_level;
  logic button_b_level;
  logic out_valid;
  logic out_ready;
  logic [15:0] lamp_level;
  logic [DIV_W-1:0] buzzer_divisor;
  logic raise_done;
  logic lower_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  level_scoreboard sb;
  logic            idling_on;
  int unsigned     holdoff_request;
  int unsigned     ticks_sent;
  int unsigned     settings_used;
  int unsigned     cycle_count = 0;

  two_button_debounced_level_control i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .button_a_level (button_a_level),
    .button_b_level (button_b_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lamp_level     (lamp_level),
    .buzzer_divisor (buzzer_divisor),
    .raise_done     (raise_done),
    .lower_done     (lower_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_levels(level_result_t'{lamp_level, buzzer_divisor, raise_done, lower_done});
  end

  // hold off the output for a counted stretch when asked, else stall at random
  initial begin
    int unsigned holdoff_left;
    out_ready = 1'b0;
    holdoff_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_request != 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
        out_ready = 1'b0;
        holdoff_left--;
      end else begin
        out_ready = !(idling_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic a_level, input logic b_level);
    while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    button_a_level = a_level;
    button_b_level = b_level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_buttons(a_level, b_level);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic repeat_tick(input logic a_level, input logic b_level, input int unsigned count);
    repeat (count) send_tick(a_level, b_level);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(index, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] debounce,
                                input logic [CFG_DATA_W-1:0] step,
                                input logic [CFG_DATA_W-1:0] level_top,
                                input logic [CFG_DATA_W-1:0] div_step,
                                input logic [CFG_DATA_W-1:0] div_top);
    write_reg(REG_DEBOUNCE_TICKS, debounce);
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_LEVEL_MAX, level_top);
    write_reg(REG_DIVISOR_STEP, div_step);
    write_reg(REG_DIVISOR_MAX, div_top);
    write_reg(CFG_IDX_W'($urandom_range(IDX_TOP, REG_COUNT)), CFG_DATA_W'($urandom));
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // one press of A, B or both, held past the debounce (or released early),
  // then released; now and then a burst of random levels instead
  task automatic press_and_release(input int unsigned a_weight);
    int unsigned pressed_ticks;
    logic        use_a;
    logic        both;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(6, 1)) send_tick(coin(), coin());
    end else begin
      use_a = $urandom_range(99) < a_weight;
      both  = !use_a && $urandom_range(3) == 0;
      pressed_ticks = sb.regs.debounce_ticks + 2 + $urandom_range(2);
      if ($urandom_range(99) < 15)
        pressed_ticks = $urandom_range(sb.regs.debounce_ticks + 1, 1);
      send_tick(!use_a && !both, use_a);
      repeat (pressed_ticks - 1) begin
        if (use_a) send_tick(1'b0, coin());
        else send_tick(coin(), 1'b0);
      end
      if (use_a) send_tick(1'b1, coin());
      else send_tick(coin(), 1'b1);
      send_tick(coin(), coin());
      repeat ($urandom_range(2)) send_tick(1'b1, 1'b1);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned a_weight;
    int unsigned quota;
    int unsigned goal;
    int unsigned pressure_at;
    logic        pressure_done;
    rst             = 1'b1;
    in_valid        = 1'b0;
    button_a_level  = 1'b1;
    button_b_level  = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    idling_on       = 1'b1;
    holdoff_request = 0;
    ticks_sent      = 0;
    settings_used   = 1;
    sb = new();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // defaults after reset: A pressed, then released while debouncing
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    drain();
    apply_settings(16'd1, 16'd4095, 16'hFFFF, 16'd15, 16'd31);
    // both pressed from idle: B wins, level and divisor at or below the step
    send_tick(1'b0, 1'b0);
    repeat_tick(1'b1, 1'b0, 2);
    repeat_tick(1'b1, 1'b1, 2);
    // raise twice: the divisor saturates on the second
    repeat (2) begin
      repeat_tick(1'b0, 1'b1, 3);
      repeat_tick(1'b1, 1'b1, 2);
    end
    // release while debouncing
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    // B held on into the release wait, then released
    repeat_tick(1'b1, 1'b0, 4);
    repeat_tick(1'b1, 1'b1, 2);

    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          apply_settings(16'd0, 16'd4095, 16'hFFFF, 16'd15, 16'd31);
          a_weight = 85;
          quota    = 250;
        end
        1: begin
          apply_settings(16'd255, 16'd1, 16'd0, 16'd1, 16'd1);
          a_weight = 30;
          quota    = 550;
        end
        default: begin
          apply_settings(CFG_DATA_W'(($urandom_range(255) << 8) | $urandom_range(6)),
                         CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                         CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
          a_weight = 50;
          quota    = 275;
        end
      endcase
      idling_on     = (phase != 0);
      goal          = ticks_sent + quota;
      pressure_at   = ticks_sent + $urandom_range(quota / 2);
      pressure_done = 1'b0;
      while (ticks_sent < goal) begin
        press_and_release(a_weight);
        if (!pressure_done && ticks_sent >= pressure_at) begin
          holdoff_request = HOLDOFF_LEN;
          pressure_done   = 1'b1;
        end
      end
    end
    idling_on = 1'b1;
    drain();

    $display("summary: %0d ticks checked over %0d register settings",
             sb.checked, settings_used);
    $display("summary: %0d raise and %0d lower actions, final level %0d divisor %0d",
             sb.raises, sb.lowers, sb.brightness, sb.divisor);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tbdlc_pkg.sv
src/tbdlc_cfg_regs.sv
src/tbdlc_press_fsm.sv
src/tbdlc_level_unit.sv
src/two_button_debounced_level_control.sv
tb/testbench.sv
